// ----- hdl/gkg_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gkg_pkg: shared types and constants of the Gaussian kernel generator
// Sequencer states, the divider request bundle, fixed-point constants and step counts.
// ----------------------------------------------------------------------------
package gkg_pkg;

    localparam logic [31:0] ONE_Q31      = 32'h8000_0000;
    localparam logic [64:0] HALF_Q31     = 65'h0_4000_0000;
    localparam logic [3:0]  TAYLOR_TERMS = 4'd13;
    localparam logic [2:0]  SQUARINGS    = 3'd5;
    localparam logic [6:0]  XQ_STEPS     = 7'd37;
    localparam logic [6:0]  TERM_STEPS   = 7'd32;
    localparam logic [6:0]  COEF_STEPS   = 7'd48;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_DEN,
        ST_TAP,
        ST_XDIV,
        ST_TMUL,
        ST_TDIV_GO,
        ST_TDIV,
        ST_SQ,
        ST_SQ_ACC,
        ST_WRITE,
        ST_RD,
        ST_CDIV_GO,
        ST_CDIV
    } gkg_state_t;

    typedef struct packed {
        logic        start;
        logic [37:0] rem_init;
        logic [63:0] bits;
        logic [6:0]  steps;
        logic [37:0] divisor;
    } gkg_div_req_t;

endpackage

// ----- hdl/gaussian_kernel_generator_top.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gaussian_kernel_generator_top: normalised Gaussian kernel generator
// Builds a 1-D or square 2-D Gaussian kernel and streams its Q1.16 taps.
// ----------------------------------------------------------------------------
// Usage:
//   Slave channel takes one request transaction: size and sigmas in s_tdata,
//   the 2-D flag in s_tuser. s_tready is high only while the block is idle.
//   Master channel returns one transaction per tap in row-major order, with
//   row and column in m_tuser and m_tlast on the final tap.
//   Per tap the weight pass runs the exponent divide, 13 Taylor terms (each
//   one multiply and a 32-step divide by the term index), followed by
//   squaring. The output pass reads the weight memory and runs a 48-step
//   divide per tap. The serial divider sets the run time of a kernel. The
//   centre tap and cut-off taps skip the maths.
//   The last coefficient sits in the output register while the next request
//   is accepted. A stalled receiver holds the output register and the
//   sequencer waits. Reset returns to idle and drops any pending output;
//   the weight memory is not cleared, every entry is written before use.
// ----------------------------------------------------------------------------
module gaussian_kernel_generator_top #(
    parameter int MAX_SIZE = 8
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [39:0] s_tdata,   // [3:0] kernel_size, [19:4] sigma_x, [35:20] sigma_y
    input  logic        s_tuser,   // [0] two_d
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [23:0] m_tdata,   // [16:0] coefficient
    output logic [5:0]  m_tuser,   // [2:0] tap_row, [5:3] tap_col
    output logic        m_tlast
);
    import gkg_pkg::*;

    localparam int DEPTH = MAX_SIZE * MAX_SIZE;
    localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam logic [3:0] MAX_SZ = 4'(MAX_SIZE);

    gkg_state_t state_reg, state_next;

    logic [3:0]  size_reg;
    logic [15:0] sx_reg, sy_reg;
    logic        two_reg;
    logic [31:0] den_reg;
    logic [2:0]  row_reg, col_reg;
    logic [AW-1:0] idx_reg;
    logic [30:0] r_reg;
    logic [31:0] term_reg, acc_reg, w_reg;
    logic [62:0] prod_reg;
    logic [63:0] sq_reg;
    logic [3:0]  k_reg;
    logic [2:0]  s_reg;
    logic [37:0] sum_reg;
    logic [31:0] rdata_reg;

    logic        m_valid_reg, m_last_reg;
    logic [16:0] m_coef_reg;
    logic [2:0]  m_row_reg, m_col_reg;

    logic [31:0] weight_mem [DEPTH];

    gkg_div_req_t div_req;
    logic         div_busy;
    logic [63:0]  div_q;

    gkg_div u_div (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .req      (div_req),
        .busy     (div_busy),
        .quotient (div_q)
    );

    // input size clamped to 1..MAX_SIZE
    logic [3:0] in_size;
    always_comb begin
        in_size = s_tdata[3:0];
        if (in_size == 4'd0) in_size = 4'd1;
        if (in_size > MAX_SZ) in_size = MAX_SZ;
    end

    // squared distance of the current tap
    logic [3:0]        centre;
    logic signed [4:0] dr, dc;
    logic [6:0]        d2;
    logic              cutoff, tap_last, out_free;
    logic [47:0]       coef_num;

    assign centre = {1'b0, size_reg[3:1]};
    assign dr = two_reg ? $signed({2'b0, row_reg}) - $signed({1'b0, centre}) : 5'sd0;
    assign dc = $signed({2'b0, col_reg}) - $signed({1'b0, centre});
    assign d2 = 7'(10'(dr * dr) + 10'(dc * dc));
    assign cutoff = {15'b0, d2, 10'b0} >= den_reg;
    assign tap_last = ({1'b0, col_reg} == size_reg - 4'd1) &&
                      (!two_reg || {1'b0, row_reg} == size_reg - 4'd1);
    assign out_free = !m_valid_reg || m_tready;
    assign coef_num = 48'({rdata_reg, 16'b0}) + 48'(sum_reg[37:1]);

    // next state
    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:    if (s_tvalid) state_next = ST_DEN;
            ST_DEN:     state_next = ST_TAP;
            ST_TAP: begin
                if (d2 == 7'd0 || den_reg == 32'd0 || cutoff) state_next = ST_WRITE;
                else state_next = ST_XDIV;
            end
            ST_XDIV:    if (!div_busy) state_next = ST_TMUL;
            ST_TMUL:    state_next = ST_TDIV_GO;
            ST_TDIV_GO: state_next = ST_TDIV;
            ST_TDIV: begin
                if (!div_busy) state_next = (k_reg == TAYLOR_TERMS) ? ST_SQ : ST_TMUL;
            end
            ST_SQ:      state_next = ST_SQ_ACC;
            ST_SQ_ACC:  state_next = (s_reg == SQUARINGS - 3'd1) ? ST_WRITE : ST_SQ;
            ST_WRITE:   state_next = tap_last ? ST_RD : ST_TAP;
            ST_RD:      state_next = ST_CDIV_GO;
            ST_CDIV_GO: state_next = ST_CDIV;
            ST_CDIV: begin
                if (!div_busy && out_free) state_next = tap_last ? ST_IDLE : ST_RD;
            end
            default:    state_next = ST_IDLE;
        endcase
    end

    // outputs of the sequencer
    always_comb begin
        s_tready = (state_reg == ST_IDLE);
        div_req  = '0;
        unique case (state_reg)
            ST_TAP: begin
                div_req.start    = !(d2 == 7'd0 || den_reg == 32'd0 || cutoff);
                div_req.rem_init = 38'({d2, 10'b0});
                div_req.steps    = XQ_STEPS;
                div_req.divisor  = 38'(den_reg);
            end
            ST_TDIV_GO: begin
                div_req.start   = 1'b1;
                div_req.bits    = {prod_reg[62:31], 32'b0};
                div_req.steps   = TERM_STEPS;
                div_req.divisor = 38'(k_reg);
            end
            ST_CDIV_GO: begin
                div_req.start   = 1'b1;
                div_req.bits    = {coef_num, 16'b0};
                div_req.steps   = COEF_STEPS;
                div_req.divisor = sum_reg;
            end
            default: div_req = '0;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg <= state_next;
            if (state_reg == ST_CDIV && !div_busy && out_free) begin
                m_valid_reg <= 1'b1;
            end else if (m_tready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    // datapath
    always_ff @(posedge aclk) begin
        case (state_reg)
            ST_IDLE: begin
                size_reg <= in_size;
                sx_reg   <= s_tdata[19:4];
                sy_reg   <= s_tdata[35:20];
                two_reg  <= s_tuser;
                row_reg  <= '0;
                col_reg  <= '0;
                idx_reg  <= '0;
                sum_reg  <= '0;
            end
            ST_DEN: den_reg <= sx_reg * (two_reg ? sy_reg : sx_reg);
            ST_TAP: begin
                w_reg    <= (d2 == 7'd0) ? ONE_Q31 : 32'd0;
                term_reg <= ONE_Q31;
                acc_reg  <= ONE_Q31;
                k_reg    <= 4'd1;
                s_reg    <= '0;
            end
            ST_XDIV:  r_reg <= div_q[36:6];
            ST_TMUL:  prod_reg <= term_reg * r_reg;
            ST_TDIV: begin
                if (!div_busy) begin
                    term_reg <= div_q[31:0];
                    acc_reg  <= k_reg[0] ? acc_reg - div_q[31:0] : acc_reg + div_q[31:0];
                    k_reg    <= k_reg + 4'd1;
                end
            end
            ST_SQ: sq_reg <= acc_reg * acc_reg;
            ST_SQ_ACC: begin
                acc_reg <= 32'(({1'b0, sq_reg} + HALF_Q31) >> 31);
                w_reg   <= 32'(({1'b0, sq_reg} + HALF_Q31) >> 31);
                s_reg   <= s_reg + 3'd1;
            end
            ST_WRITE: begin
                weight_mem[idx_reg] <= w_reg;
                sum_reg <= sum_reg + 38'(w_reg);
                if (tap_last) begin
                    idx_reg <= '0;
                    row_reg <= '0;
                    col_reg <= '0;
                end else begin
                    idx_reg <= idx_reg + AW'(1);
                    if ({1'b0, col_reg} == size_reg - 4'd1) begin
                        col_reg <= '0;
                        row_reg <= row_reg + 3'd1;
                    end else begin
                        col_reg <= col_reg + 3'd1;
                    end
                end
            end
            ST_RD: rdata_reg <= weight_mem[idx_reg];
            ST_CDIV: begin
                if (!div_busy && out_free) begin
                    m_coef_reg <= div_q[16:0];
                    m_row_reg  <= row_reg;
                    m_col_reg  <= col_reg;
                    m_last_reg <= tap_last;
                    idx_reg    <= idx_reg + AW'(1);
                    if ({1'b0, col_reg} == size_reg - 4'd1) begin
                        col_reg <= '0;
                        row_reg <= row_reg + 3'd1;
                    end else begin
                        col_reg <= col_reg + 3'd1;
                    end
                end
            end
            default: ;
        endcase
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = {7'b0, m_coef_reg};
    assign m_tuser  = {m_col_reg, m_row_reg};
    assign m_tlast  = m_last_reg;

`ifndef SYNTH
    a_idle_div: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_IDLE) |-> !div_busy)
        else $error("divider busy while idle");
    a_load_free: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && !m_tready) |=> !(state_reg == ST_IDLE && $past(state_reg) == ST_CDIV)
            || $past(m_tvalid && m_tready) || !$past(m_tvalid))
        else $error("output register overwritten while stalled");
    a_start_idle: assert property (@(posedge aclk) disable iff (!aresetn)
        div_req.start |-> !div_busy)
        else $error("divider restarted while busy");
`endif

endmodule

// ----- hdl/gkg_div.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gkg_div: serial restoring divider
// Shifts one dividend bit per cycle into the partial remainder, one quotient
// bit per cycle out. The remainder may be preloaded (must stay below divisor).
// ----------------------------------------------------------------------------
module gkg_div (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  gkg_pkg::gkg_div_req_t req,
    output logic                 busy,
    output logic [63:0]          quotient
);
    import gkg_pkg::*;

    logic        busy_reg;
    logic [37:0] rem_reg;
    logic [63:0] bits_reg;
    logic [63:0] q_reg;
    logic [6:0]  cnt_reg;
    logic [37:0] div_reg;

    logic [38:0] trial;
    logic        fits;

    assign trial = {rem_reg, bits_reg[63]};
    assign fits  = trial >= {1'b0, div_reg};

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
        end else if (req.start) begin
            busy_reg <= 1'b1;
        end else if (busy_reg && cnt_reg == 7'd1) begin
            busy_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (req.start) begin
            rem_reg  <= req.rem_init;
            bits_reg <= req.bits;
            q_reg    <= '0;
            cnt_reg  <= req.steps;
            div_reg  <= req.divisor;
        end else if (busy_reg) begin
            rem_reg  <= fits ? 38'(trial - {1'b0, div_reg}) : trial[37:0];
            bits_reg <= {bits_reg[62:0], 1'b0};
            q_reg    <= {q_reg[62:0], fits};
            cnt_reg  <= cnt_reg - 7'd1;
        end
    end

    assign busy     = busy_reg;
    assign quotient = q_reg;

endmodule
